/* sv/ezc_pkg.sv */
// Package for the edge to grid zone cell lister.
// Holds payload structs, register indexes, the sequencer state type and fixed widths.
`timescale 1ns / 1ps

package ezc_pkg;

   // Fixed field widths.
   localparam int COORD_W     = 20;
   localparam int REGION_W    = 16;
   localparam int ZONE_W      = 4;
   localparam int GRID_W      = 5;
   localparam int ZSIZE_W     = 8;
   localparam int MAX_RESULTS = 60;
   localparam int COUNT_W     = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_X    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_Z    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_SIZE = 2'd2;

   // One input item: an edge and its owner region.
   typedef struct packed {
      logic [COORD_W-1:0]  start_x;
      logic [COORD_W-1:0]  start_z;
      logic [COORD_W-1:0]  end_x;
      logic [COORD_W-1:0]  end_z;
      logic [REGION_W-1:0] region_number;
   } ezc_req_type;

   // One result item: a touched zone.
   typedef struct packed {
      logic [ZONE_W-1:0]   zone_col;
      logic [ZONE_W-1:0]   zone_row;
      logic [REGION_W-1:0] owner_region;
      logic                cell_valid;
      logic                last_cell;
   } ezc_rsp_type;

   // Request from the sequencer to the output buffer.
   typedef struct packed {
      logic                push;
      logic                finish;
      logic [ZONE_W-1:0]   col;
      logic [ZONE_W-1:0]   row;
      logic [REGION_W-1:0] region;
   } ezc_push_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ZDIV,
      S_ZWAIT,
      S_DECIDE,
      S_SCAN,
      S_XSETUP,
      S_XMULD,
      S_XMULT,
      S_XMULP,
      S_XP1,
      S_XCHECK,
      S_XSUM,
      S_XDIV,
      S_XWAIT,
      S_XEMIT1,
      S_XEMIT2,
      S_FINISH
   } ezc_state_type;

endpackage

/* sv/ezc_div.sv */
// Iterative restoring divider shared by all zone index and crossing divisions.
// One quotient bit per cycle; depends on nothing but its parameters.
`timescale 1ns / 1ps

module ezc_div #(
   parameter int NW = 40,
   parameter int DW = 36,
   parameter int QW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int SW = DW + QW - 1;
   localparam int RW = (NW > SW) ? NW : SW;
   localparam int CW = (QW > 1) ? $clog2(QW) : 1;

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [RW-1:0] rem_ff;
   logic [RW-1:0] ds_ff;
   logic [QW-1:0] q_ff;
   logic          ge;

   // The quotient is known to fit in QW bits, so the divisor starts shifted left by QW-1 bits.
   assign ge = rem_ff >= ds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Shift and subtract datapath.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= RW'(dividend);
         ds_ff  <= RW'(divisor) << (QW - 1);
         cnt_ff <= CW'(QW - 1);
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - ds_ff;
         end
         ds_ff  <= ds_ff >> 1;
         q_ff   <= {q_ff[QW-2:0], ge};
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

/* sv/ezc_outbuf.sv */
// Output stage: holds the newest cell back one step so the final one can be marked last.
// Uses ezc_pkg for the payload and request structs.
`timescale 1ns / 1ps

module ezc_outbuf import ezc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ezc_push_type push,
   output logic         push_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ezc_rsp_type  rsp_item
);

   logic              pend_valid_ff;
   logic              pend_valid_in;
   logic [ZONE_W-1:0] pend_col_ff;
   logic [ZONE_W-1:0] pend_row_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   ezc_rsp_type       rsp_item_ff;
   ezc_rsp_type       rsp_item_in;
   logic              out_free;
   logic              take;
   logic              load_out;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign push_ready = push.finish ? out_free : (!pend_valid_ff || out_free);
   assign take       = (push.push || push.finish) && push_ready;
   assign load_out   = take && (push.finish || pend_valid_ff);

   // Choose what moves into the output register.
   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_item_in.zone_col     = pend_col_ff;
         rsp_item_in.zone_row     = pend_row_ff;
         rsp_item_in.owner_region = push.region;
         rsp_item_in.cell_valid   = 1'b1;
         rsp_item_in.last_cell    = push.finish;
         if (push.finish && !pend_valid_ff) begin
            // Empty answer: no zone of the edge lies on the grid.
            rsp_item_in.zone_col   = '0;
            rsp_item_in.zone_row   = '0;
            rsp_item_in.cell_valid = 1'b0;
         end
      end
      pend_valid_in = pend_valid_ff;
      if (take) begin
         pend_valid_in = push.push && !push.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      if (take && push.push) begin
         pend_col_ff <= push.col;
         pend_row_ff <= push.row;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

/* sv/ezc_ctrl.sv */
// Sequencer that walks one edge through zone divisions, scans and line crossings.
// Uses ezc_pkg and instantiates the shared divider ezc_div.
`timescale 1ns / 1ps

module ezc_ctrl import ezc_pkg::*; #(
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ezc_req_type        req_item,
   input  logic [GRID_W-1:0]  grid_x_lim,
   input  logic [GRID_W-1:0]  grid_z_lim,
   input  logic [ZSIZE_W-1:0] zone_meters,
   output ezc_push_type       push,
   input  logic               push_ready
);

   localparam int QW   = COORD_W - COORD_FRAC_BITS;
   localparam int TQW  = QW + 1;
   localparam int ZSW  = ZSIZE_W + COORD_FRAC_BITS;
   localparam int MW   = COORD_W + 2;
   localparam int PW   = 2 * MW;
   localparam int NUMW = 2 * COORD_W;
   localparam int DENW = COORD_W + ZSW;
   localparam int TW   = TQW + ZSW;

   ezc_state_type state_ff;
   ezc_state_type state_in;

   ezc_req_type          item_ff;
   logic [1:0]           zi_ff;
   logic [QW-1:0]        zone_ff [4];
   logic [QW-1:0]        i_ff;
   logic [QW-1:0]        hi_ff;
   logic [QW-1:0]        fixed_ff;
   logic                 scan_x_ff;
   logic                 phase_ff;
   logic [COORD_W-1:0]   ua_ff;
   logic [COORD_W-1:0]   va_ff;
   logic [COORD_W-1:0]   du_ff;
   logic signed [COORD_W:0] dv_ff;
   logic [TQW-1:0]       t_ff;
   logic [TQW-1:0]       tend_ff;
   logic [TW-1:0]        tpos_ff;
   logic [DENW-1:0]      den_ff;
   logic [NUMW-1:0]      p1_ff;
   logic [NUMW-1:0]      num_ff;
   logic [QW-1:0]        k_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic signed [PW-1:0] mul_ff;

   logic [ZSIZE_W-1:0]   zs_meters;
   logic [ZSW-1:0]       zs;
   logic signed [MW-1:0] mul_a;
   logic signed [MW-1:0] mul_b;
   logic [TW-1:0]        tdiff;
   logic signed [PW:0]   sum;

   logic                 div_start;
   logic [NUMW-1:0]      div_dividend;
   logic [DENW-1:0]      div_divisor;
   logic                 div_done;
   logic [QW-1:0]        div_q;

   logic                 cell_act;
   logic [TQW-1:0]       cell_col;
   logic [TQW-1:0]       cell_row;
   logic                 in_grid;
   logic                 push_take;
   logic                 stall;
   logic                 cap_hit;

   logic [COORD_W-1:0]   set_ua;
   logic [COORD_W-1:0]   set_va;
   logic [COORD_W-1:0]   set_ub;
   logic [COORD_W-1:0]   set_vb;
   logic [QW-1:0]        set_t0;
   logic [QW-1:0]        set_t1;
   logic [TQW-1:0]       set_lim;

   logic [QW-1:0]        lo_x;
   logic [QW-1:0]        hi_x;
   logic [QW-1:0]        lo_z;
   logic [QW-1:0]        hi_z;

   // Zone side in coordinate units; a zero size counts as one.
   assign zs_meters = (zone_meters == '0) ? ZSIZE_W'(1) : zone_meters;
   assign zs        = ZSW'(zs_meters) << COORD_FRAC_BITS;

   // Shared divider for zone indexes and crossing points.
   assign div_start   = (state_ff == S_ZDIV) || (state_ff == S_XDIV);
   assign div_divisor = (state_ff == S_ZDIV) ? DENW'(zs) : den_ff;

   always_comb begin
      unique case (zi_ff)
         2'd0:    div_dividend = NUMW'(item_ff.start_x);
         2'd1:    div_dividend = NUMW'(item_ff.start_z);
         2'd2:    div_dividend = NUMW'(item_ff.end_x);
         default: div_dividend = NUMW'(item_ff.end_z);
      endcase
      if (state_ff != S_ZDIV) begin
         div_dividend = num_ff;
      end
   end

   ezc_div #(
      .NW(NUMW),
      .DW(DENW),
      .QW(QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // Scan bounds for the single row and single column cases.
   always_comb begin
      lo_x = (zone_ff[0] < zone_ff[2]) ? zone_ff[0] : zone_ff[2];
      hi_x = (zone_ff[0] < zone_ff[2]) ? zone_ff[2] : zone_ff[0];
      if (hi_x > QW'(grid_x_lim)) begin
         hi_x = QW'(grid_x_lim);
      end
      lo_z = (zone_ff[1] < zone_ff[3]) ? zone_ff[1] : zone_ff[3];
      hi_z = (zone_ff[1] < zone_ff[3]) ? zone_ff[3] : zone_ff[1];
      if (hi_z > QW'(grid_z_lim)) begin
         hi_z = QW'(grid_z_lim);
      end
   end

   // Ends of the edge ordered along the axis whose lines are crossed.
   always_comb begin
      if (!phase_ff) begin
         if (item_ff.start_z < item_ff.end_z) begin
            set_ua = item_ff.start_z;  set_va = item_ff.start_x;
            set_ub = item_ff.end_z;    set_vb = item_ff.end_x;
            set_t0 = zone_ff[1];       set_t1 = zone_ff[3];
         end else begin
            set_ua = item_ff.end_z;    set_va = item_ff.end_x;
            set_ub = item_ff.start_z;  set_vb = item_ff.start_x;
            set_t0 = zone_ff[3];       set_t1 = zone_ff[1];
         end
         set_lim = TQW'(grid_z_lim);
      end else begin
         if (item_ff.start_x < item_ff.end_x) begin
            set_ua = item_ff.start_x;  set_va = item_ff.start_z;
            set_ub = item_ff.end_x;    set_vb = item_ff.end_z;
            set_t0 = zone_ff[0];       set_t1 = zone_ff[2];
         end else begin
            set_ua = item_ff.end_x;    set_va = item_ff.end_z;
            set_ub = item_ff.start_x;  set_vb = item_ff.start_z;
            set_t0 = zone_ff[2];       set_t1 = zone_ff[0];
         end
         set_lim = TQW'(grid_x_lim);
      end
   end

   // Shared multiplier operands, one product per cycle.
   assign tdiff = tpos_ff - TW'(ua_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_XMULD: begin
            mul_a = MW'(du_ff);
            mul_b = MW'(zs);
         end
         S_XMULT: begin
            mul_a = MW'(t_ff);
            mul_b = MW'(zs);
         end
         S_XMULP: begin
            mul_a = MW'(va_ff);
            mul_b = MW'(du_ff);
         end
         S_XCHECK: begin
            mul_a = MW'(tdiff[COORD_W-1:0]);
            mul_b = MW'(dv_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign sum = (PW + 1)'($signed({1'b0, p1_ff})) + (PW + 1)'(mul_ff);

   // Cell offered to the output buffer in this cycle.
   always_comb begin
      cell_act = 1'b0;
      cell_col = '0;
      cell_row = '0;
      unique case (state_ff)
         S_SCAN: begin
            cell_act = i_ff <= hi_ff;
            cell_col = scan_x_ff ? TQW'(i_ff) : TQW'(fixed_ff);
            cell_row = scan_x_ff ? TQW'(fixed_ff) : TQW'(i_ff);
         end
         S_XEMIT1, S_XEMIT2: begin
            cell_act = 1'b1;
            if (state_ff == S_XEMIT1) begin
               cell_col = phase_ff ? t_ff : TQW'(k_ff);
               cell_row = phase_ff ? TQW'(k_ff) : t_ff;
            end else begin
               cell_col = phase_ff ? (t_ff - TQW'(1)) : TQW'(k_ff);
               cell_row = phase_ff ? TQW'(k_ff) : (t_ff - TQW'(1));
            end
         end
         default: begin
            cell_act = 1'b0;
         end
      endcase
   end

   assign in_grid   = (cell_col < TQW'(grid_x_lim)) && (cell_row < TQW'(grid_z_lim));
   assign push_take = push.push && push_ready;
   assign stall     = push.push && !push_ready;
   assign cap_hit   = push_take && (count_ff == COUNT_W'(MAX_RESULTS - 1));

   assign push.push   = cell_act && in_grid;
   assign push.finish = state_ff == S_FINISH;
   assign push.col    = cell_col[ZONE_W-1:0];
   assign push.row    = cell_row[ZONE_W-1:0];
   assign push.region = item_ff.region_number;

   assign req_ready = state_ff == S_IDLE;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_ZDIV;
            end
         end
         S_ZDIV: state_in = S_ZWAIT;
         S_ZWAIT: begin
            if (div_done) begin
               state_in = (zi_ff == 2'd3) ? S_DECIDE : S_ZDIV;
            end
         end
         S_DECIDE: begin
            if (zone_ff[1] == zone_ff[3] || zone_ff[0] == zone_ff[2]) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_XSETUP;
            end
         end
         S_SCAN: begin
            if (!cell_act || cap_hit) begin
               state_in = S_FINISH;
            end
         end
         S_XSETUP: state_in = S_XMULD;
         S_XMULD:  state_in = S_XMULT;
         S_XMULT:  state_in = S_XMULP;
         S_XMULP:  state_in = S_XP1;
         S_XP1:    state_in = S_XCHECK;
         S_XCHECK: begin
            if (t_ff > tend_ff) begin
               state_in = phase_ff ? S_FINISH : S_XSETUP;
            end else begin
               state_in = S_XSUM;
            end
         end
         S_XSUM: state_in = S_XDIV;
         S_XDIV: state_in = S_XWAIT;
         S_XWAIT: begin
            if (div_done) begin
               state_in = S_XEMIT1;
            end
         end
         S_XEMIT1: begin
            if (cap_hit) begin
               state_in = S_FINISH;
            end else if (!stall) begin
               state_in = S_XEMIT2;
            end
         end
         S_XEMIT2: begin
            if (cap_hit) begin
               state_in = S_FINISH;
            end else if (!stall) begin
               state_in = S_XCHECK;
            end
         end
         S_FINISH: begin
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers, loaded as the sequencer steps.
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (push_take) begin
         count_ff <= count_ff + COUNT_W'(1);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_ff  <= req_item;
               zi_ff    <= 2'd0;
               count_ff <= '0;
            end
         end
         S_ZWAIT: begin
            if (div_done) begin
               zone_ff[zi_ff] <= div_q;
               zi_ff          <= zi_ff + 2'd1;
            end
         end
         S_DECIDE: begin
            phase_ff <= 1'b0;
            if (zone_ff[1] == zone_ff[3]) begin
               scan_x_ff <= 1'b1;
               fixed_ff  <= zone_ff[1];
               i_ff      <= lo_x;
               hi_ff     <= hi_x;
            end else begin
               scan_x_ff <= 1'b0;
               fixed_ff  <= zone_ff[0];
               i_ff      <= lo_z;
               hi_ff     <= hi_z;
            end
         end
         S_SCAN: begin
            if (cell_act && !stall) begin
               i_ff <= i_ff + QW'(1);
            end
         end
         S_XSETUP: begin
            ua_ff   <= set_ua;
            va_ff   <= set_va;
            du_ff   <= set_ub - set_ua;
            dv_ff   <= $signed({1'b0, set_vb}) - $signed({1'b0, set_va});
            t_ff    <= TQW'(set_t0) + TQW'(1);
            tend_ff <= (TQW'(set_t1) > set_lim) ? set_lim : TQW'(set_t1);
         end
         S_XMULT: den_ff  <= mul_ff[DENW-1:0];
         S_XMULP: tpos_ff <= mul_ff[TW-1:0];
         S_XP1:   p1_ff   <= mul_ff[NUMW-1:0];
         S_XCHECK: begin
            if (t_ff > tend_ff) begin
               phase_ff <= 1'b1;
            end
         end
         S_XSUM: begin
            // A crossing lies between the ends; a negative numerator is clamped to zero.
            num_ff <= sum[PW] ? '0 : sum[NUMW-1:0];
         end
         S_XWAIT: begin
            if (div_done) begin
               k_ff <= div_q;
            end
         end
         S_XEMIT2: begin
            if (!stall) begin
               t_ff    <= t_ff + TQW'(1);
               tpos_ff <= tpos_ff + TW'(zs);
            end
         end
         default: begin
            zi_ff <= zi_ff;
         end
      endcase
   end

endmodule

/* sv/edge_to_grid_zone_cells_top.sv */
// Edge to grid zone cells: lists the grid zones touched by one polygon edge.
// Steps: accept, four zone divisions on the shared divider and a decision; then either a scan
// along the single row or column, or per axis a setup and then a divide per zone line crossing,
// then a finish step; output back pressure adds stalls.
// One edge at a time: a new edge is taken only while the sequencer is idle.
// Reset is synchronous and active high; it restores the registers to 16, 16 and 16.
`timescale 1ns / 1ps

module edge_to_grid_zone_cells_top import ezc_pkg::*; #(
   parameter int MAX_ZONES_PER_SIDE = 16,
   parameter int COORD_FRAC_BITS    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ezc_req_type            req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ezc_rsp_type            rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [GRID_W-1:0] MAX_ZONES = GRID_W'(MAX_ZONES_PER_SIDE);

   logic [GRID_W-1:0]  grid_x_ff;
   logic [GRID_W-1:0]  grid_z_ff;
   logic [ZSIZE_W-1:0] zone_size_ff;
   logic [GRID_W-1:0]  grid_x_lim;
   logic [GRID_W-1:0]  grid_z_lim;
   ezc_push_type       push;
   logic               push_ready;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff    <= GRID_W'(16);
         grid_z_ff    <= GRID_W'(16);
         zone_size_ff <= ZSIZE_W'(16);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_X:    grid_x_ff    <= csr_wdata[GRID_W-1:0];
            CSR_GRID_Z:    grid_z_ff    <= csr_wdata[GRID_W-1:0];
            CSR_ZONE_SIZE: zone_size_ff <= csr_wdata[ZSIZE_W-1:0];
            default:       zone_size_ff <= zone_size_ff;
         endcase
      end
   end

   // Grid sizes above the supported side saturate.
   assign grid_x_lim = (grid_x_ff > MAX_ZONES) ? MAX_ZONES : grid_x_ff;
   assign grid_z_lim = (grid_z_ff > MAX_ZONES) ? MAX_ZONES : grid_z_ff;

   ezc_ctrl #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .grid_x_lim  (grid_x_lim),
      .grid_z_lim  (grid_z_lim),
      .zone_meters (zone_size_ff),
      .push        (push),
      .push_ready  (push_ready)
   );

   ezc_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule
